// File: hdl/rmrc_pkg.sv
// Types and constants for the rectangular multicast route computation.
`timescale 1ns / 1ps
`default_nettype none

package rmrc_pkg;

  localparam int COORD_W    = 4;
  localparam int PORT_W     = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;
  localparam int ROUTE_W    = 5;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNICAST   = 2'd0,
    KIND_MULTICAST = 2'd1,
    KIND_BROADCAST = 2'd2,
    KIND_OTHER     = 2'd3
  } kind_t;

  typedef enum logic [PORT_W-1:0] {
    PORT_NORTH = 3'd0,
    PORT_EAST  = 3'd1,
    PORT_SOUTH = 3'd2,
    PORT_WEST  = 3'd3,
    PORT_LOCAL = 3'd4
  } port_t;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_Y = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] in_port;
    coord_t            rect_bottom;
    coord_t            rect_right;
    coord_t            rect_top;
    coord_t            rect_left;
    coord_t            src_y;
    coord_t            src_x;
  } hdr_t;

  // to_north sits in bit 0.
  typedef struct packed {
    logic to_local;
    logic to_east;
    logic to_west;
    logic to_south;
    logic to_north;
  } route_t;

endpackage

`default_nettype wire

// File: hdl/rect_multicast_route_compute_core.sv
// Route computation for one 2-D mesh router with rectangular multicast.
//
// Channels: the header item enters on s_axis (packet kind in tuser, the
// coordinates, rectangle corners and arrival port in tdata). The output
// port set leaves on m_axis as five bits of tdata. The router's own
// coordinates are written through the cfg channel (index 0 node_x,
// index 1 node_y), which is always ready; write it only while idle.
// Path: an accepted item is held in the input register, which feeds the
// route logic; the route logic loads the result register, whose output is
// valid at m_axis. Throughput: one item per cycle; both registers advance
// together whenever the result register is empty or being taken.
// When the receiver stalls, the result holds and the input register
// fills; s_axis_tready then drops until m_axis_tready returns.
// Reset (rst, synchronous, active high) empties both registers and sets
// node_x and node_y to 0.
`timescale 1ns / 1ps
`default_nettype none

module rect_multicast_route_compute_core
  import rmrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // [3:0] src_x, [7:4] src_y, [11:8] rect_left, [15:12] rect_top,
  // [19:16] rect_right, [23:20] rect_bottom, [26:24] in_port, rest zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] packet_kind
  input  wire logic [KIND_W-1:0]     s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] to_north, [1] to_south, [2] to_west, [3] to_east, [4] to_local,
  // rest zero
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  coord_t node_x;
  coord_t node_y;
  logic   in_valid;
  hdr_t   hdr;
  logic   out_valid;
  route_t route;
  route_t route_next;
  logic   advance;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-ROUTE_W){1'b0}}, route};

  always_ff @(posedge clk) begin
    if (rst) begin
      node_x <= '0;
      node_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE_X: node_x <= cfg_data[COORD_W-1:0];
        CFG_NODE_Y: node_y <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      hdr.kind        <= s_axis_tuser;
      hdr.src_x       <= s_axis_tdata[3:0];
      hdr.src_y       <= s_axis_tdata[7:4];
      hdr.rect_left   <= s_axis_tdata[11:8];
      hdr.rect_top    <= s_axis_tdata[15:12];
      hdr.rect_right  <= s_axis_tdata[19:16];
      hdr.rect_bottom <= s_axis_tdata[23:20];
      hdr.in_port     <= s_axis_tdata[26:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      route <= route_next;
    end
  end

  function automatic coord_t clamp(coord_t v, coord_t lo, coord_t hi);
    coord_t r;
    if (v <= lo) begin
      r = lo;
    end else if (v >= hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic   in_rect;
  logic   first_node;
  logic   can_n;
  logic   can_s;
  logic   can_w;
  logic   can_e;
  route_t step;
  route_t fan;

  always_comb begin
    in_rect = (node_x >= hdr.rect_left) && (node_x <= hdr.rect_right) &&
              (node_y >= hdr.rect_top) && (node_y <= hdr.rect_bottom);
    first_node = (clamp(hdr.src_x, hdr.rect_left, hdr.rect_right) == node_x) &&
                 (clamp(hdr.src_y, hdr.rect_top, hdr.rect_bottom) == node_y);
    can_n = node_y != hdr.rect_top;
    can_s = node_y != hdr.rect_bottom;
    can_w = node_x != hdr.rect_left;
    can_e = node_x != hdr.rect_right;

    step = '0;
    if (node_x < hdr.rect_left) begin
      step.to_east = 1'b1;
    end else if (node_x > hdr.rect_right) begin
      step.to_west = 1'b1;
    end else if (node_y > hdr.rect_bottom) begin
      step.to_north = 1'b1;
    end else if (node_y < hdr.rect_top) begin
      step.to_south = 1'b1;
    end

    fan = '0;
    fan.to_local = 1'b1;
    if (first_node) begin
      fan.to_north = can_n;
      fan.to_south = can_s;
      fan.to_west  = can_w;
      fan.to_east  = can_e;
    end else begin
      unique case (hdr.in_port)
        PORT_NORTH: fan.to_south = can_s;
        PORT_SOUTH: fan.to_north = can_n;
        PORT_WEST: begin
          fan.to_north = can_n;
          fan.to_south = can_s;
          fan.to_east  = can_e;
        end
        PORT_EAST: begin
          fan.to_north = can_n;
          fan.to_south = can_s;
          fan.to_west  = can_w;
        end
        PORT_LOCAL: begin
          fan.to_local = 1'b0;
          fan.to_north = can_n;
          fan.to_south = can_s;
          fan.to_west  = can_w;
          fan.to_east  = can_e;
        end
        default: ;
      endcase
    end

    case (hdr.kind) inside
      KIND_UNICAST: route_next = step;
      KIND_MULTICAST, KIND_BROADCAST: route_next = in_rect ? fan : step;
      default: route_next = '0;
    endcase
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> in_valid)
    else $error("accepted item did not reach the input register");

  a_other_empty: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && hdr.kind == KIND_OTHER |=> m_axis_tdata == '0)
    else $error("unknown packet kind produced a port");

  a_unicast_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && hdr.kind == KIND_UNICAST |=> $onehot0(route))
    else $error("unicast item routed to more than one port");

  a_stay_in_rect: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && hdr.kind != KIND_UNICAST && hdr.kind != KIND_OTHER &&
    in_rect && node_y == hdr.rect_top && node_y != hdr.rect_bottom
    |=> !route.to_north)
    else $error("fan-out left the rectangle through its top edge");

endmodule

`default_nettype wire
